>>> src/ptdt_pkg.sv
package ptdt_pkg;

    // Table geometry.
    localparam int SLOTS    = 8;
    localparam int TASK_IDS = 16;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NFREE_W  = $clog2(SLOTS + 1);

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Command codes as they arrive on the input word.
    localparam logic [2:0] CMD_TICK      = 3'd0;
    localparam logic [2:0] CMD_ADD       = 3'd1;
    localparam logic [2:0] CMD_REMOVE    = 3'd2;
    localparam logic [2:0] CMD_CLEAR     = 3'd3;
    localparam logic [2:0] CMD_RESET_CNT = 3'd4;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_ADD,
        OP_REMOVE,
        OP_CLEAR,
        OP_RESET_CNT,
        OP_BAD
    } op_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_TICK,
        B_TICK_END,
        B_REMOVE
    } back_state_t;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] time_ms;
        logic [3:0]         task_id;
        logic [30:0]        interval_ms;
        logic signed [31:0] start_ms;
        logic [15:0]        allowed_mask;
    } req_t;

    typedef struct packed {
        logic        fired;
        logic        ok;
        logic [2:0]  slot;
        logic [3:0]  out_task_id;
        logic [30:0] elapsed_ms;
        logic        last_item;
    } rsp_t;

    // Classified command as it travels through the queue.
    typedef struct packed {
        op_t         op;
        logic [31:0] time_ms;
        logic [3:0]  task_id;
        logic [30:0] interval_ms;
        logic [31:0] start_ms;
        logic [15:0] allowed_mask;
    } work_t;

endpackage

>>> src/ptdt_front.sv
module ptdt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ptdt_pkg::req_t    req,
    output logic              busy,
    input  logic              q_full,
    output logic              push,
    output ptdt_pkg::work_t   push_item
);

    logic            front_valid_reg;
    logic            front_valid_next;
    ptdt_pkg::work_t front_item_reg;
    ptdt_pkg::work_t front_item_next;
    ptdt_pkg::op_t   op_dec;
    logic            accept;

    // Map the raw command code onto an operation class.
    always_comb
    begin
        case (req.cmd)
            ptdt_pkg::CMD_TICK:      op_dec = ptdt_pkg::OP_TICK;
            ptdt_pkg::CMD_ADD:       op_dec = ptdt_pkg::OP_ADD;
            ptdt_pkg::CMD_REMOVE:    op_dec = ptdt_pkg::OP_REMOVE;
            ptdt_pkg::CMD_CLEAR:     op_dec = ptdt_pkg::OP_CLEAR;
            ptdt_pkg::CMD_RESET_CNT: op_dec = ptdt_pkg::OP_RESET_CNT;
            default:                 op_dec = ptdt_pkg::OP_BAD;
        endcase
    end

    assign busy      = front_valid_reg;
    assign accept    = start && !front_valid_reg;
    assign push      = front_valid_reg && !q_full;
    assign push_item = front_item_reg;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        front_item_next  = front_item_reg;
        if (accept)
        begin
            front_valid_next             = 1'b1;
            front_item_next.op           = op_dec;
            front_item_next.time_ms      = req.time_ms;
            front_item_next.task_id      = req.task_id;
            front_item_next.interval_ms  = req.interval_ms;
            front_item_next.start_ms     = req.start_ms;
            front_item_next.allowed_mask = req.allowed_mask;
        end
        else if (push)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_item_reg <= front_item_next;
    end

endmodule

>>> src/ptdt_queue.sv
module ptdt_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ptdt_pkg::work_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output ptdt_pkg::work_t head
);

    ptdt_pkg::work_t                entry_reg [ptdt_pkg::QUEUE_DEPTH];
    logic [ptdt_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [ptdt_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [ptdt_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [ptdt_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [ptdt_pkg::QCNT_W-1:0]    count_reg;
    logic [ptdt_pkg::QCNT_W-1:0]    count_next;
    logic                           do_push;
    logic                           do_pop;

    assign full    = (count_reg == ptdt_pkg::QCNT_W'(ptdt_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointers wrap at the depth, which need not be a power of two.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == ptdt_pkg::QPTR_W'(ptdt_pkg::QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == ptdt_pkg::QPTR_W'(ptdt_pkg::QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

>>> src/ptdt_back.sv
module ptdt_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  ptdt_pkg::work_t q_head,
    output logic            pop,
    output logic            valid,
    output ptdt_pkg::rsp_t  rsp
);

    localparam int SW = ptdt_pkg::SLOT_W;
    localparam int NS = ptdt_pkg::SLOTS;

    // Slot table, one register set per slot.
    logic               slot_valid_reg [NS];
    logic               slot_valid_next [NS];
    logic [3:0]         slot_task_reg [NS];
    logic [3:0]         slot_task_next [NS];
    logic [30:0]        slot_ivl_reg [NS];
    logic [30:0]        slot_ivl_next [NS];
    logic [31:0]        slot_last_reg [NS];
    logic [31:0]        slot_last_next [NS];

    logic [ptdt_pkg::NFREE_W-1:0] next_free_reg;
    logic [ptdt_pkg::NFREE_W-1:0] next_free_next;

    ptdt_pkg::back_state_t state_reg;
    ptdt_pkg::back_state_t state_next;
    logic [SW-1:0]         idx_reg;
    logic [SW-1:0]         idx_next;
    ptdt_pkg::work_t       work_reg;
    ptdt_pkg::work_t       work_next;

    // A fired result is held back one step so that the final one can carry last_item.
    logic                  pend_valid_reg;
    logic                  pend_valid_next;
    ptdt_pkg::rsp_t        pend_reg;
    ptdt_pkg::rsp_t        pend_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    ptdt_pkg::rsp_t        out_reg;
    ptdt_pkg::rsp_t        out_next;

    logic [31:0]           cur_diff;
    logic                  cur_allowed;
    logic                  cur_fire;
    logic                  idx_last;

    function automatic ptdt_pkg::rsp_t make_rsp(
        input logic        fired,
        input logic        ok,
        input logic [2:0]  slot,
        input logic [3:0]  id,
        input logic [30:0] elapsed,
        input logic        last
    );
        ptdt_pkg::rsp_t r;
        r.fired       = fired;
        r.ok          = ok;
        r.slot        = slot;
        r.out_task_id = id;
        r.elapsed_ms  = elapsed;
        r.last_item   = last;
        return r;
    endfunction

    assign valid = out_valid_reg;
    assign rsp   = out_reg;

    // One slot is examined per cycle of a tick scan.
    assign cur_diff    = work_reg.time_ms - slot_last_reg[idx_reg];
    assign cur_allowed = (int'(slot_task_reg[idx_reg]) < ptdt_pkg::TASK_IDS)
                         && work_reg.allowed_mask[slot_task_reg[idx_reg]];
    assign cur_fire    = slot_valid_reg[idx_reg] && !cur_diff[31]
                         && (cur_diff[30:0] >= slot_ivl_reg[idx_reg]) && cur_allowed;
    assign idx_last    = (idx_reg == SW'(NS - 1));
    assign pop         = (state_reg == ptdt_pkg::B_IDLE) && !q_empty;

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        slot_task_next  = slot_task_reg;
        slot_ivl_next   = slot_ivl_reg;
        slot_last_next  = slot_last_reg;
        next_free_next  = next_free_reg;
        state_next      = state_reg;
        idx_next        = idx_reg;
        work_next       = work_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = 1'b0;
        out_next        = out_reg;

        case (state_reg)
            ptdt_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    work_next = q_head;
                    idx_next  = '0;
                    case (q_head.op)
                        ptdt_pkg::OP_TICK:
                        begin
                            pend_valid_next = 1'b0;
                            state_next      = ptdt_pkg::B_TICK;
                        end
                        ptdt_pkg::OP_REMOVE:
                        begin
                            state_next = ptdt_pkg::B_REMOVE;
                        end
                        ptdt_pkg::OP_ADD:
                        begin
                            out_valid_next = 1'b1;
                            if (next_free_reg < ptdt_pkg::NFREE_W'(NS))
                            begin
                                slot_valid_next[next_free_reg[SW-1:0]] = 1'b1;
                                slot_task_next[next_free_reg[SW-1:0]]  = q_head.task_id;
                                slot_ivl_next[next_free_reg[SW-1:0]]   = q_head.interval_ms;
                                slot_last_next[next_free_reg[SW-1:0]]  = q_head.start_ms;
                                next_free_next = next_free_reg + 1'b1;
                                out_next = make_rsp(1'b0, 1'b1, 3'(next_free_reg[SW-1:0]),
                                                    4'd0, 31'd0, 1'b1);
                            end
                            else
                            begin
                                out_next = make_rsp(1'b0, 1'b0, 3'd0, 4'd0, 31'd0, 1'b1);
                            end
                        end
                        ptdt_pkg::OP_CLEAR:
                        begin
                            for (int i = 0; i < NS; i++)
                                slot_valid_next[i] = 1'b0;
                            next_free_next = '0;
                            out_valid_next = 1'b1;
                            out_next = make_rsp(1'b0, 1'b1, 3'd0, 4'd0, 31'd0, 1'b1);
                        end
                        ptdt_pkg::OP_RESET_CNT:
                        begin
                            for (int i = 0; i < NS; i++)
                                if (slot_valid_reg[i])
                                    slot_last_next[i] = {1'b0, slot_ivl_reg[i]};
                            out_valid_next = 1'b1;
                            out_next = make_rsp(1'b0, 1'b1, 3'd0, 4'd0, 31'd0, 1'b1);
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_next = make_rsp(1'b0, 1'b0, 3'd0, 4'd0, 31'd0, 1'b1);
                        end
                    endcase
                end
            end

            ptdt_pkg::B_TICK:
            begin
                if (cur_fire)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = pend_reg;
                    end
                    pend_valid_next         = 1'b1;
                    pend_next               = make_rsp(1'b1, 1'b1, 3'(idx_reg),
                                                       slot_task_reg[idx_reg],
                                                       cur_diff[30:0], 1'b0);
                    slot_last_next[idx_reg] = work_reg.time_ms;
                end
                if (idx_last)
                    state_next = ptdt_pkg::B_TICK_END;
                else
                    idx_next = idx_reg + 1'b1;
            end

            ptdt_pkg::B_TICK_END:
            begin
                out_valid_next = 1'b1;
                if (pend_valid_reg)
                begin
                    out_next           = pend_reg;
                    out_next.last_item = 1'b1;
                end
                else
                begin
                    out_next = make_rsp(1'b0, 1'b0, 3'd0, 4'd0, 31'd0, 1'b1);
                end
                pend_valid_next = 1'b0;
                state_next      = ptdt_pkg::B_IDLE;
            end

            ptdt_pkg::B_REMOVE:
            begin
                if (slot_valid_reg[idx_reg] && (slot_task_reg[idx_reg] == work_reg.task_id))
                begin
                    slot_valid_next[idx_reg] = 1'b0;
                    out_valid_next = 1'b1;
                    out_next = make_rsp(1'b0, 1'b1, 3'(idx_reg), 4'd0, 31'd0, 1'b1);
                    state_next = ptdt_pkg::B_IDLE;
                end
                else if (idx_last)
                begin
                    out_valid_next = 1'b1;
                    out_next = make_rsp(1'b0, 1'b0, 3'd0, 4'd0, 31'd0, 1'b1);
                    state_next = ptdt_pkg::B_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ptdt_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ptdt_pkg::B_IDLE;
            idx_reg        <= '0;
            next_free_reg  <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NS; i++)
                slot_valid_reg[i] <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            next_free_reg  <= next_free_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            slot_valid_reg <= slot_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg      <= work_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
        slot_task_reg <= slot_task_next;
        slot_ivl_reg  <= slot_ivl_next;
        slot_last_reg <= slot_last_next;
    end

endmodule

>>> src/periodic_task_dispatch_table.sv
// Channel   Ports              Handshake                       Payload
// command   start, busy, req   taken when start=1 and busy=0   ptdt_pkg::req_t
// result    valid, rsp         one cycle per word, no stall    ptdt_pkg::rsp_t
//
// A command word waits in the front register, with busy high, until the
// two-word queue to the back has room. A tick scans the slots one per cycle
// through the shared subtract and compare; remove scans until the id matches
// or the last slot is seen; add, clear and counter reset are done in idle.
// Reset clears the valid marks, the add pointer and all control state.
// Results cannot be held off, so each word shows for one cycle.
module periodic_task_dispatch_table (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  ptdt_pkg::req_t req,
    output logic           busy,
    output logic           valid,
    output ptdt_pkg::rsp_t rsp
);

    // Front to queue.
    logic            push;
    ptdt_pkg::work_t push_item;
    logic            q_full;

    // Queue to back.
    logic            pop;
    logic            q_empty;
    ptdt_pkg::work_t q_head;

    // The front decodes the command and holds the word until the queue has room.
    ptdt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    // The queue lets the front take new commands while a tick scan is running.
    ptdt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    // The back owns the slot table and produces every result word.
    ptdt_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .pop     (pop),
        .valid   (valid),
        .rsp     (rsp)
    );

endmodule

>>> tb/sv/periodic_task_dispatch_table_test.sv
module periodic_task_dispatch_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Command codes beyond the defined set. The block must answer these with a
    // single empty word and leave the table alone.
    localparam logic [2:0] CMD_SPARE_LO = ptdt_pkg::CMD_RESET_CNT + 3'd1;
    localparam logic [2:0] CMD_SPARE_HI = '1;

    localparam int RANDOM_ITEMS = 290;
    // Once the backlog is this short the sender stops leaving gaps, so the
    // tail of the run has back-to-back commands.
    localparam int QUIET_TAIL   = 40;
    // Drain time for four tick scans through the back end.
    localparam int DRAIN_CYCLES = 4 * (ptdt_pkg::SLOTS + 2);
    localparam int REPORT_LIMIT = 10;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    ptdt_pkg::req_t req = '0;
    logic busy;
    logic valid;
    ptdt_pkg::rsp_t rsp;

    // Command words waiting to be offered, and the result words that the
    // block still owes, oldest first.
    ptdt_pkg::req_t cmd_backlog[$];
    ptdt_pkg::rsp_t due_words[$];

    // Our own copy of the dispatch table.
    bit          tbl_valid  [ptdt_pkg::SLOTS];
    logic [3:0]  tbl_task   [ptdt_pkg::SLOTS];
    logic [30:0] tbl_period [ptdt_pkg::SLOTS];
    logic [31:0] tbl_last   [ptdt_pkg::SLOTS];
    int unsigned tbl_next;

    int unsigned mismatches = 0;
    int unsigned posted     = 0;
    int unsigned gap_left   = 0;
    bit          gaps_on    = 1'b1;

    periodic_task_dispatch_table uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .valid (valid),
        .rsp   (rsp)
    );

    always #6 clk = ~clk;

    function automatic ptdt_pkg::rsp_t word_of(logic fired, logic ok, logic [2:0] slot,
                                               logic [3:0] id, logic [30:0] elapsed,
                                               logic last);
        ptdt_pkg::rsp_t r;
        r.fired       = fired;
        r.ok          = ok;
        r.slot        = slot;
        r.out_task_id = id;
        r.elapsed_ms  = elapsed;
        r.last_item   = last;
        return r;
    endfunction

    // Work out the words that one accepted command produces and bring the
    // table copy up to date.
    function automatic void predict_dispatch(ptdt_pkg::req_t w);
        bit          hit     [ptdt_pkg::SLOTS];
        logic [30:0] elapsed [ptdt_pkg::SLOTS];
        logic [31:0] diff;
        int          last_hit;
        int          found;
        last_hit = -1;
        found    = -1;
        case (w.cmd)
            ptdt_pkg::CMD_TICK:
            begin
                // A slot is due when the wrapped difference is non-negative and
                // at least its period, and the mode allows its task id. Each
                // slot's outcome depends only on its own state, so the firing
                // set can be settled before any word is queued.
                for (int i = 0; i < ptdt_pkg::SLOTS; i++)
                begin
                    hit[i] = 1'b0;
                    elapsed[i] = '0;
                    if (tbl_valid[i])
                    begin
                        diff = w.time_ms - tbl_last[i];
                        if (!diff[31] && diff[30:0] >= tbl_period[i] &&
                            tbl_task[i] < ptdt_pkg::TASK_IDS && w.allowed_mask[tbl_task[i]])
                        begin
                            hit[i]     = 1'b1;
                            elapsed[i] = diff[30:0];
                            last_hit   = i;
                            tbl_last[i] = w.time_ms;
                        end
                    end
                end
                if (last_hit < 0)
                    due_words.push_back(word_of(1'b0, 1'b0, '0, '0, '0, 1'b1));
                else
                    for (int i = 0; i < ptdt_pkg::SLOTS; i++)
                        if (hit[i])
                            due_words.push_back(word_of(1'b1, 1'b1, ptdt_pkg::SLOT_W'(i),
                                                        tbl_task[i], elapsed[i],
                                                        i == last_hit));
            end
            ptdt_pkg::CMD_ADD:
            begin
                // Slots are handed out once only; a removed slot stays used
                // until the table is cleared.
                if (tbl_next < ptdt_pkg::SLOTS)
                begin
                    tbl_valid[tbl_next]  = 1'b1;
                    tbl_task[tbl_next]   = w.task_id;
                    tbl_period[tbl_next] = w.interval_ms;
                    tbl_last[tbl_next]   = w.start_ms;
                    due_words.push_back(word_of(1'b0, 1'b1, ptdt_pkg::SLOT_W'(tbl_next),
                                                '0, '0, 1'b1));
                    tbl_next++;
                end
                else
                    due_words.push_back(word_of(1'b0, 1'b0, '0, '0, '0, 1'b1));
            end
            ptdt_pkg::CMD_REMOVE:
            begin
                for (int i = 0; i < ptdt_pkg::SLOTS; i++)
                    if (found < 0 && tbl_valid[i] && tbl_task[i] == w.task_id)
                        found = i;
                if (found >= 0)
                begin
                    tbl_valid[found] = 1'b0;
                    due_words.push_back(word_of(1'b0, 1'b1, ptdt_pkg::SLOT_W'(found),
                                                '0, '0, 1'b1));
                end
                else
                    due_words.push_back(word_of(1'b0, 1'b0, '0, '0, '0, 1'b1));
            end
            ptdt_pkg::CMD_CLEAR:
            begin
                for (int i = 0; i < ptdt_pkg::SLOTS; i++)
                    tbl_valid[i] = 1'b0;
                tbl_next = 0;
                due_words.push_back(word_of(1'b0, 1'b1, '0, '0, '0, 1'b1));
            end
            ptdt_pkg::CMD_RESET_CNT:
            begin
                for (int i = 0; i < ptdt_pkg::SLOTS; i++)
                    if (tbl_valid[i])
                        tbl_last[i] = {1'b0, tbl_period[i]};
                due_words.push_back(word_of(1'b0, 1'b1, '0, '0, '0, 1'b1));
            end
            default:
                due_words.push_back(word_of(1'b0, 1'b0, '0, '0, '0, 1'b1));
        endcase
    endfunction

    task automatic report_mismatch(string what, ptdt_pkg::rsp_t want, ptdt_pkg::rsp_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t %s: expected fired=%0d ok=%0d slot=%0d id=%0d elapsed=%0d last=%0d, got fired=%0d ok=%0d slot=%0d id=%0d elapsed=%0d last=%0d",
                     $realtime, what,
                     want.fired, want.ok, want.slot, want.out_task_id, want.elapsed_ms,
                     want.last_item,
                     got.fired, got.ok, got.slot, got.out_task_id, got.elapsed_ms,
                     got.last_item);
    endtask

    task automatic post(logic [2:0] cmd, logic [31:0] now_ms, int unsigned id,
                        int unsigned period, logic [31:0] first_ms, int unsigned mask);
        ptdt_pkg::req_t w;
        w.cmd          = cmd;
        w.time_ms      = now_ms;
        w.task_id      = 4'(id);
        w.interval_ms  = 31'(period);
        w.start_ms     = first_ms;
        w.allowed_mask = 16'(mask);
        cmd_backlog.push_back(w);
        posted++;
    endtask

    // Periods are mostly short so that tasks come due often, with the odd
    // zero period and the odd period anywhere in the full range.
    function automatic logic [30:0] draw_period();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 31'($urandom >> 1);
        else if (pick == 1)
            return '0;
        return 31'($urandom_range(0, 300));
    endfunction

    // Mostly permissive masks, sometimes a sparse or an empty one.
    function automatic logic [15:0] draw_mask();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        else if (pick < 4)
            return 16'($urandom);
        else if (pick < 7)
            return 16'($urandom | $urandom);
        return '1;
    endfunction

    // Sender. A command word is offered until the block takes it; between
    // words the sender may pause at random. The prediction is made at the edge
    // where the word is taken, so it follows the order in which the block sees
    // the commands.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            req      <= '0;
            gap_left = 0;
            gaps_on  = 1'b1;
        end
        else
        begin
            if (start && !busy)
                predict_dispatch(req);
            if (!(start && busy))
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (cmd_backlog.size() == 0)
                    start <= 1'b0;
                else if (gaps_on && cmd_backlog.size() > QUIET_TAIL &&
                         $urandom_range(0, 4) == 0)
                begin
                    gap_left = $urandom_range(0, 6);
                    start <= 1'b0;
                end
                else
                begin
                    req   <= cmd_backlog.pop_front();
                    start <= 1'b1;
                end
            end
            // Switch between stretches with and without pauses now and then.
            if ($urandom_range(0, 39) == 0)
                gaps_on = !gaps_on;
        end
    end

    // Receiver. Every result word is present for one cycle only, so each
    // strobe is checked against the oldest word still owed.
    always @(posedge clk)
    begin : result_check
        ptdt_pkg::rsp_t want;
        if (rst_n && valid)
        begin
            if (due_words.size() == 0)
                report_mismatch("unexpected word", '0, rsp);
            else
            begin
                want = due_words.pop_front();
                if (rsp.fired !== want.fired || rsp.ok !== want.ok ||
                    rsp.slot !== want.slot || rsp.out_task_id !== want.out_task_id ||
                    rsp.elapsed_ms !== want.elapsed_ms || rsp.last_item !== want.last_item)
                    report_mismatch("word mismatch", want, rsp);
            end
        end
    end

    initial
    begin : stimulus
        int          pick;
        int unsigned random_from;
        logic [31:0] now_ms;

        // Directed part. An empty table first: a tick is idle and a remove
        // finds nothing.
        post(ptdt_pkg::CMD_TICK, 32'd0, 4'd0, '0, 32'd0, 16'hFFFF);
        post(ptdt_pkg::CMD_REMOVE, 32'd0, 4'd3, '0, 32'd0, 16'h0000);
        // Fill all eight slots: zero and full-scale periods, start times at
        // both ends of the signed range, and one id used twice.
        post(ptdt_pkg::CMD_ADD, 32'd0, 4'd0, 31'd0, 32'd0, 16'h0000);
        post(ptdt_pkg::CMD_ADD, 32'd0, 4'd15, 31'h7FFF_FFFF, 32'h8000_0000, 16'h0000);
        post(ptdt_pkg::CMD_ADD, 32'd0, 4'd5, 31'd100, 32'd1000, 16'h0000);
        post(ptdt_pkg::CMD_ADD, 32'd0, 4'd5, 31'd50, 32'd1000, 16'h0000);
        post(ptdt_pkg::CMD_ADD, 32'd0, 4'd9, 31'd10, 32'h7FFF_FFFF, 16'h0000);
        post(ptdt_pkg::CMD_ADD, 32'd0, 4'd1, 31'd1, 32'd2000, 16'h0000);
        post(ptdt_pkg::CMD_ADD, 32'd0, 4'd2, 31'd20, 32'd0, 16'h0000);
        post(ptdt_pkg::CMD_ADD, 32'd0, 4'd3, 31'd30, 32'd0, 16'h0000);
        // The table is full now.
        post(ptdt_pkg::CMD_ADD, 32'd0, 4'd4, 31'd5, 32'd0, 16'h0000);
        // With no mode controller nothing may run; then a tick with several
        // tasks due, one of them exactly on its period, and some with a
        // negative difference.
        post(ptdt_pkg::CMD_TICK, 32'd1100, 4'd0, '0, 32'd0, 16'h0000);
        post(ptdt_pkg::CMD_TICK, 32'd1100, 4'd0, '0, 32'd0, 16'hFFFF);
        // Time running backwards gives negative differences only.
        post(ptdt_pkg::CMD_TICK, 32'd1099, 4'd0, '0, 32'd0, 16'hFFFF);
        // Exactly due across the signed wrap, only task nine allowed.
        post(ptdt_pkg::CMD_TICK, 32'h8000_0009, 4'd0, '0, 32'd0, 16'h0200);
        // The full-scale period elapses exactly.
        post(ptdt_pkg::CMD_TICK, 32'hFFFF_FFFF, 4'd0, '0, 32'd0, 16'h8000);
        post(ptdt_pkg::CMD_RESET_CNT, 32'd0, 4'd0, '0, 32'd0, 16'h0000);
        post(ptdt_pkg::CMD_TICK, 32'h7FFF_FFFF, 4'd0, '0, 32'd0, 16'hFFFF);
        // Removing a duplicated id takes the first slot, then the second,
        // then misses; the freed slots are not handed out again.
        post(ptdt_pkg::CMD_REMOVE, 32'd0, 4'd5, '0, 32'd0, 16'h0000);
        post(ptdt_pkg::CMD_REMOVE, 32'd0, 4'd5, '0, 32'd0, 16'h0000);
        post(ptdt_pkg::CMD_REMOVE, 32'd0, 4'd5, '0, 32'd0, 16'h0000);
        post(ptdt_pkg::CMD_ADD, 32'd0, 4'd6, 31'd1, 32'd0, 16'h0000);
        post(CMD_SPARE_LO, 32'hFFFF_FFFF, 4'hF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        post(CMD_SPARE_HI, 32'hFFFF_FFFF, 4'hF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        post(ptdt_pkg::CMD_CLEAR, 32'd0, 4'd0, '0, 32'd0, 16'h0000);
        post(ptdt_pkg::CMD_ADD, 32'd0, 4'd7, 31'd0, 32'd0, 16'h0000);
        post(ptdt_pkg::CMD_TICK, 32'd0, 4'd0, '0, 32'd0, 16'h0080);

        // Random part. Each round clears the table, fills some or all of it
        // with tasks whose start times sit just behind a running clock, and
        // then mostly ticks that clock forward, mixed with removes, adds,
        // counter resets and the occasional arbitrary word.
        random_from = posted;
        now_ms = $urandom;
        while (posted - random_from < RANDOM_ITEMS)
        begin
            post(ptdt_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
            repeat ($urandom_range(1, ptdt_pkg::SLOTS + 1))
                post(ptdt_pkg::CMD_ADD, $urandom, $urandom, draw_period(),
                     now_ms - $urandom_range(0, 200), $urandom);
            repeat ($urandom_range(6, 24))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    now_ms += $urandom_range(0, 150);
                    post(ptdt_pkg::CMD_TICK, now_ms, $urandom, $urandom, $urandom,
                         draw_mask());
                end
                else if (pick < 65)
                    post(ptdt_pkg::CMD_REMOVE, $urandom, $urandom, $urandom, $urandom,
                         $urandom);
                else if (pick < 72)
                    post(ptdt_pkg::CMD_RESET_CNT, $urandom, $urandom, $urandom, $urandom,
                         $urandom);
                else if (pick < 80)
                    post(ptdt_pkg::CMD_ADD, $urandom, $urandom, draw_period(),
                         now_ms - $urandom_range(0, 200), $urandom);
                else if (pick < 88)
                    post(ptdt_pkg::CMD_TICK, $urandom, $urandom, $urandom, $urandom,
                         draw_mask());
                else if (pick < 95)
                    post(3'($urandom_range(ptdt_pkg::CMD_TICK, CMD_SPARE_HI)), $urandom,
                         $urandom, $urandom, $urandom, $urandom);
                else
                    post(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), $urandom,
                         $urandom, $urandom, $urandom, $urandom);
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Let every command go in, every owed word come out, and then give
        // the block time to show any word it should not produce.
        while (cmd_backlog.size() != 0 || start)
            @(posedge clk);
        while (due_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && due_words.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Safety net: the slowest correct run needs well under a tenth of this.
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> files.f
src/ptdt_pkg.sv
src/ptdt_front.sv
src/ptdt_queue.sv
src/ptdt_back.sv
src/periodic_task_dispatch_table.sv
tb/sv/periodic_task_dispatch_table_test.sv
